// ===== sv/palette_fade_sequencer_core_macros.svh =====
// Assertion helpers for the fade sequencer core.
`ifndef PALETTE_FADE_SEQUENCER_CORE_MACROS_SVH
`define PALETTE_FADE_SEQUENCER_CORE_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define PFS_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PFS_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/pfs_pkg.sv =====
package pfs_pkg;

  // Palette store
  localparam int PALETTE_ENTRIES = 16;
  localparam int IDX_W = 4;
  localparam int RGB_W = 24;
  localparam int COMP_W = 8;

  // Configuration
  localparam int TPS_W = 24;
  localparam int SIZE_W = 5;
  localparam int CFG_IDX_W = 2;
  localparam logic [TPS_W-1:0] TPS_RESET = TPS_W'(1193180);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(16);
  localparam logic [SIZE_W-1:0] PAL_MAX = SIZE_W'(PALETTE_ENTRIES);
  localparam logic [CFG_IDX_W-1:0] CFG_TPS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;

  // Stream fields
  localparam int MODE_W = 2;
  localparam int DT_W = 16;
  localparam int PHASE_W = 2;
  localparam int IN_DATA_W = 48;
  localparam int OUT_DATA_W = 32;
  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

  // Fade phases
  localparam logic [PHASE_W-1:0] PH_REVEAL = 2'd0;
  localparam logic [PHASE_W-1:0] PH_WHITE = 2'd1;
  localparam logic [PHASE_W-1:0] PH_BACK = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DONE = 2'd3;

  // Timing and divider
  localparam int TIMER_W = 25;          // holds up to twice the largest time base
  localparam int DEN_W = 25;            // half or double of the time base
  localparam int DIV_W = 35;            // timer shifted by the 10-bit scale
  localparam int SCALE_SH = 10;
  localparam int QUO_W = 18;            // product bits 17:10 need only these
  localparam int CNT_W = $clog2(DIV_W + 1);

endpackage

// ===== sv/pfs_ram.sv =====
module pfs_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/pfs_div.sv =====
module pfs_div
  import pfs_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [DIV_W-1:0] quo
);

  logic [DIV_W-1:0] acc;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] dsr;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try a subtract
  assign trial = {rem, acc[DIV_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign quo   = acc;

  // Iterate one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        acc <= num;
        rem <= '0;
        dsr <= den;
        cnt <= CNT_W'(DIV_W);
      end else if (cnt != '0) begin
        if (fits) begin
          rem <= DEN_W'(trial - {1'b0, dsr});
        end else begin
          rem <= trial[DEN_W-1:0];
        end
        acc  <= {acc[DIV_W-2:0], fits};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CNT_W'(1));
      end
    end
  end

endmodule

// ===== sv/palette_fade_sequencer_core.sv =====
// Palette fade sequencer.
// Input stream s_axis: tuser carries the mode (tick, write entry, read entry),
// tdata the tick length, entry index and a background colour. Every accepted
// word returns one word on m_axis: the displayed colour of that entry after
// the item, and the fade phase.
// Configuration: cfg_index 0 writes the time base, 1 the palette size; cfg_ready
// is always high, and writes are to be made by the user only while no item is in
// flight; the block itself does not enforce this. One item is worked on at a time.
// A phase 1 or 2 entry takes one 35-step division shared by all three components;
// the entry being revealed in phase 0 takes one 35-step division per color
// component; with a time base too small to divide by, or where no quotient is
// needed, no division is made. The shared restoring divider, one quotient bit per
// cycle, does these divisions.
// The next input word is accepted once the previous result sits in the output
// register; if the receiver stalls, the finished result of the next item waits
// in the sequencer until the output register frees up.
// Reset clears the fade to phase 0 with entry counter and timer at zero, and
// loads the default time base and palette size; palette entries are undefined
// until written.
`include "palette_fade_sequencer_core_macros.svh"

module palette_fade_sequencer_core
  import pfs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // Input stream
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // tdata: tick_length[15:0], entry_index[19:16], red_in[27:20], green_in[35:28],
  //        blue_in[43:36], zero[47:44]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: mode[1:0]
  input  logic [MODE_W-1:0]     s_axis_tuser,
  // Output stream
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // tdata: red_out[7:0], green_out[15:8], blue_out[23:16], fade_phase[25:24],
  //        zero[31:26]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // Configuration write channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [TPS_W-1:0]      cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_FETCH, S_PREP, S_DIV, S_MUL, S_COMB, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    K_KEEP, K_ZERO, K_WHITE, K_REVEAL, K_BRIGHT, K_DARK
  } kind_t;

  state_t               state;
  kind_t                kind;
  kind_t                kind_next;

  logic [TPS_W-1:0]     tps;
  logic [SIZE_W-1:0]    psize;

  logic [PHASE_W-1:0]   phase;
  logic                 finished;
  logic [SIZE_W-1:0]    counter;
  logic [TIMER_W-1:0]   timer;

  logic [MODE_W-1:0]    mode_r;
  logic [DT_W-1:0]      dt_r;
  logic [IDX_W-1:0]     idx_r;
  logic [1:0]           k;
  logic [QUO_W-1:0]     quo;
  logic [COMP_W+QUO_W-1:0] prod;
  logic [COMP_W-1:0]    res [3];

  logic                 in_acc;
  logic                 ram_we;
  logic [RGB_W-1:0]     pix;
  logic [COMP_W-1:0]    cur_c;
  logic [SIZE_W-1:0]    act;
  logic [DEN_W-1:0]     dur;
  logic                 den_zero;
  logic [TIMER_W:0]     tsum;
  logic [SIZE_W-1:0]    idx_x;
  logic                 need_div;
  logic                 div_start;
  logic [DIV_W-1:0]     div_num;
  logic                 div_done;
  logic [DIV_W-1:0]     div_quo;
  logic [COMP_W-1:0]    comp_val;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign ram_we        = in_acc && (s_axis_tuser == MODE_WRITE);

  // Palette store
  pfs_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s_axis_tdata[19:16]),
    .wdata ({s_axis_tdata[27:20], s_axis_tdata[35:28], s_axis_tdata[43:36]}),
    .re    (state == S_UPD),
    .raddr (idx_r),
    .rdata (pix)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tps   <= TPS_RESET;
      psize <= SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_TPS) begin
        tps <= cfg_data;
      end else if (cfg_index == CFG_SIZE) begin
        psize <= cfg_data[SIZE_W-1:0];
      end
    end
  end

  // Shared timing terms: phase duration doubles as the divisor
  assign act      = (psize > PAL_MAX) ? PAL_MAX : psize;
  assign dur      = (phase == PH_BACK) ? {tps, 1'b0} : {2'b00, tps[TPS_W-1:1]};
  assign den_zero = (dur == '0);
  assign tsum     = {1'b0, timer} + (TIMER_W + 1)'(dt_r);
  assign idx_x    = {1'b0, idx_r};

  // Select the current colour component, red first
  always_comb begin
    case (k)
      2'd0:    cur_c = pix[23:16];
      2'd1:    cur_c = pix[15:8];
      default: cur_c = pix[7:0];
    endcase
  end

  // Classify how the addressed entry is displayed in the current phase
  always_comb begin
    if (phase == PH_DONE) begin
      kind_next = K_KEEP;
    end else if (phase == PH_REVEAL) begin
      if (idx_x < counter) begin
        kind_next = K_KEEP;
      end else if (idx_x == counter && idx_x < act) begin
        kind_next = K_REVEAL;
      end else begin
        kind_next = K_ZERO;
      end
    end else if (phase == PH_BACK && finished) begin
      kind_next = K_KEEP;
    end else if (idx_x >= act) begin
      kind_next = K_ZERO;
    end else if (phase == PH_WHITE) begin
      kind_next = finished ? K_WHITE : K_BRIGHT;
    end else begin
      kind_next = K_DARK;
    end
  end

  // Divider request: per component while revealing, once for the fade scale
  always_comb begin
    need_div = 1'b0;
    case (kind)
      K_REVEAL:         need_div = !den_zero;
      K_BRIGHT, K_DARK: need_div = !den_zero && (k == 2'd0);
      default:          need_div = 1'b0;
    endcase
  end

  assign div_start = (state == S_PREP) && need_div;
  assign div_num   = (kind == K_REVEAL) ? DIV_W'(cur_c * timer)
                                        : {timer, SCALE_SH'(0)};

  pfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (dur),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Final component value from the registered quotient and product
  always_comb begin
    case (kind)
      K_KEEP:   comp_val = cur_c;
      K_WHITE:  comp_val = 8'hFF;
      K_REVEAL: comp_val = quo[COMP_W-1:0];
      K_BRIGHT: comp_val = cur_c + prod[SCALE_SH +: COMP_W];
      K_DARK:   comp_val = ~prod[SCALE_SH +: COMP_W];
      default:  comp_val = '0;
    endcase
  end

  // Sequencer, fade state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_REVEAL;
      finished      <= 1'b0;
      counter       <= '0;
      timer         <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // Drop the taken output word unless a new one is loaded below
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            mode_r <= s_axis_tuser;
            dt_r   <= s_axis_tdata[15:0];
            idx_r  <= s_axis_tdata[19:16];
            state  <= S_UPD;
          end
        end
        S_UPD: begin
          // Advance the fade on a tick; the palette read is issued here too
          if (mode_r == MODE_TICK && phase != PH_DONE) begin
            if (finished || (phase == PH_REVEAL && counter >= act)) begin
              phase    <= phase + 1'b1;
              finished <= 1'b0;
            end else if (tsum > {1'b0, dur}) begin
              timer <= '0;
              if (phase == PH_REVEAL) begin
                counter <= counter + 1'b1;
              end else begin
                finished <= 1'b1;
              end
            end else begin
              timer <= tsum[TIMER_W-1:0];
            end
          end
          state <= S_FETCH;
        end
        S_FETCH: begin
          kind  <= kind_next;
          k     <= 2'd0;
          state <= S_PREP;
        end
        S_PREP: begin
          case (kind)
            K_REVEAL, K_BRIGHT, K_DARK: begin
              if (need_div) begin
                state <= S_DIV;
              end else begin
                if (den_zero) begin
                  quo <= '0;
                end
                state <= S_MUL;
              end
            end
            default: state <= S_COMB;
          endcase
        end
        S_DIV: begin
          if (div_done) begin
            quo   <= div_quo[QUO_W-1:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= (8'hFF - cur_c) * quo;
          state <= S_COMB;
        end
        S_COMB: begin
          res[k] <= comp_val;
          if (k == 2'd2) begin
            state <= S_OUT;
          end else begin
            k     <= k + 1'b1;
            state <= S_PREP;
          end
        end
        S_OUT: begin
          // Hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tdata  <= {6'b0, phase, res[2], res[1], res[0]};
            m_axis_tvalid <= 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `PFS_ASSERT_NEXT(a_done_sticky, phase == PH_DONE, phase == PH_DONE, "fade left done phase")
  `PFS_ASSERT_NOW(a_fin_phase, finished, phase == PH_WHITE || phase == PH_BACK, "stray finish")
  `PFS_ASSERT_NOW(a_cnt_range, 1'b1, counter <= PAL_MAX, "entry counter beyond palette")
  `PFS_ASSERT_NOW(a_div_owner, div_done, state == S_DIV, "divider finished while not awaited")

endmodule

// ===== tb/tb_palette_fade_sequencer_core.sv =====
module tb_palette_fade_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;
  import pfs_pkg::*;

  localparam int RANDOM_ITEMS = 650;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 200;
  localparam int MAX_SHOWN = 10;
  localparam longint unsigned FULL_SCALE = 255;
  // Mode code the block treats as a plain read
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [DT_W-1:0]   dt;
    logic [IDX_W-1:0]  idx;
    logic [COMP_W-1:0] r;
    logic [COMP_W-1:0] g;
    logic [COMP_W-1:0] b;
  } fade_word_t;

  typedef struct {
    logic [COMP_W-1:0]  r;
    logic [COMP_W-1:0]  g;
    logic [COMP_W-1:0]  b;
    logic [PHASE_W-1:0] ph;
  } shown_color_t;

  logic clk;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [MODE_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TPS_W-1:0] cfg_data = '0;

  palette_fade_sequencer_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Fade state mirrored from the block
  logic [RGB_W-1:0]   bg_pal [PALETTE_ENTRIES];
  logic [PHASE_W-1:0] fade_ph = PH_REVEAL;
  bit                 ph_finished = 1'b0;
  int unsigned        reveal_cnt = 0;
  longint unsigned    fade_tmr = 0;
  longint unsigned    tps_cfg = TPS_RESET;
  int unsigned        size_cfg = SIZE_RESET;

  fade_word_t   pending_q [$];
  shown_color_t shown_q [$];
  fade_word_t   on_bus;
  bit           throttle_in = 1'b1;
  bit           throttle_out = 1'b1;
  int unsigned  send_gap;
  int unsigned  hold_left;
  int unsigned  quiet_cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  words_checked = 0;
  int unsigned  settings_used = 0;
  int unsigned  phase_hits [4] = '{0, 0, 0, 0};

  function automatic longint unsigned quot(longint unsigned num, longint unsigned den);
    return (den == 0) ? 64'd0 : num / den;
  endfunction

  function automatic int unsigned live_entries();
    return (size_cfg > PALETTE_ENTRIES) ? PALETTE_ENTRIES : size_cfg;
  endfunction

  // Displayed level of one color component of entry idx
  function automatic logic [COMP_W-1:0] shade(logic [COMP_W-1:0] c, int unsigned idx);
    longint unsigned half;
    longint unsigned dbl;
    longint unsigned s;
    longint unsigned cw;
    longint unsigned inv;
    half = tps_cfg / 2;
    dbl = tps_cfg * 2;
    cw = c;
    inv = FULL_SCALE - cw;
    if (fade_ph == PH_DONE) return c;
    if (fade_ph == PH_REVEAL) begin
      if (idx < reveal_cnt) return c;
      if (idx == reveal_cnt && idx < live_entries())
        return COMP_W'(quot(cw * fade_tmr, half));
      return '0;
    end
    if (fade_ph == PH_BACK && ph_finished) return c;
    if (idx >= live_entries()) return '0;
    if (fade_ph == PH_WHITE) begin
      if (ph_finished) return {COMP_W{1'b1}};
      s = quot(fade_tmr << SCALE_SH, half);
      return COMP_W'(cw + ((inv * s) >> SCALE_SH));
    end
    s = quot(fade_tmr << SCALE_SH, dbl);
    return COMP_W'(FULL_SCALE - ((inv * s) >> SCALE_SH));
  endfunction

  // Advance the fade by one tick of dt time units
  function automatic void step_fade(logic [DT_W-1:0] dt);
    longint unsigned dur;
    if (fade_ph == PH_DONE) return;
    if (ph_finished || (fade_ph == PH_REVEAL && reveal_cnt >= live_entries())) begin
      fade_ph = fade_ph + 1'b1;
      ph_finished = 1'b0;
      return;
    end
    dur = (fade_ph == PH_BACK) ? tps_cfg * 2 : tps_cfg / 2;
    fade_tmr += dt;
    if (fade_tmr > dur) begin
      fade_tmr = 0;
      if (fade_ph == PH_REVEAL) reveal_cnt++;
      else ph_finished = 1'b1;
    end
  endfunction

  // Apply an accepted word and queue the color it should report
  function automatic void apply_word(fade_word_t w);
    shown_color_t want;
    logic [RGB_W-1:0] bg;
    if (w.mode == MODE_TICK) step_fade(w.dt);
    else if (w.mode == MODE_WRITE) bg_pal[w.idx] = {w.r, w.g, w.b};
    bg = bg_pal[w.idx];
    want.r = shade(bg[23:16], w.idx);
    want.g = shade(bg[15:8], w.idx);
    want.b = shade(bg[7:0], w.idx);
    want.ph = fade_ph;
    shown_q.push_back(want);
    phase_hits[fade_ph]++;
  endfunction

  function automatic void check_word(logic [OUT_DATA_W-1:0] d);
    shown_color_t want;
    words_checked++;
    if (shown_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("%0t: result word %h with nothing pending", $time, d);
      return;
    end
    want = shown_q.pop_front();
    if (d[7:0] != want.r || d[15:8] != want.g || d[23:16] != want.b ||
        d[25:24] != want.ph) begin
      mismatches++;
      if (mismatches <= MAX_SHOWN)
        $display("%0t: mismatch rgb/phase expected %h %h %h /%0d got %h %h %h /%0d", $time,
                 want.r, want.g, want.b, want.ph, d[7:0], d[15:8], d[23:16], d[25:24]);
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic logic [COMP_W-1:0] pick_comp();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 10) return '0;
    if (roll < 20) return {COMP_W{1'b1}};
    return COMP_W'($urandom);
  endfunction

  function automatic void enqueue_word(logic [MODE_W-1:0] mode, logic [DT_W-1:0] dt,
                                       logic [IDX_W-1:0] idx, logic [COMP_W-1:0] r,
                                       logic [COMP_W-1:0] g, logic [COMP_W-1:0] b);
    fade_word_t w;
    w.mode = mode;
    w.dt = dt;
    w.idx = idx;
    w.r = r;
    w.g = g;
    w.b = b;
    pending_q.push_back(w);
  endfunction

  function automatic void enqueue_random(int unsigned count);
    int unsigned roll;
    int unsigned dt_roll;
    logic [MODE_W-1:0] mode;
    logic [DT_W-1:0] dt;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      dt_roll = $urandom_range(0, 99);
      if (roll < 40) mode = MODE_TICK;
      else if (roll < 65) mode = MODE_READ;
      else if (roll < 90) mode = MODE_WRITE;
      else mode = MODE_SPARE;
      if (dt_roll < 15) dt = '0;
      else if (dt_roll < 25) dt = '1;
      else if (dt_roll < 50) dt = DT_W'($urandom_range(0, 255));
      else dt = DT_W'($urandom);
      enqueue_word(mode, dt, IDX_W'($urandom), pick_comp(), pick_comp(), pick_comp());
    end
  endfunction

  // Wait until no word is pending or in flight
  task automatic drain_all();
    while (pending_q.size() != 0 || s_axis_tvalid || shown_q.size() != 0) @(negedge clk);
  endtask

  // Write both registers back to back, keeping valid high between them
  task automatic set_fade_config(logic [TPS_W-1:0] tps, logic [SIZE_W-1:0] entries);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_TPS;
    cfg_data <= tps;
    do @(posedge clk); while (!cfg_ready);
    tps_cfg = tps;
    cfg_index <= CFG_SIZE;
    cfg_data <= TPS_W'(entries);
    do @(posedge clk); while (!cfg_ready);
    size_cfg = entries;
    cfg_valid <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  // Input driver: present queued words, with random gaps
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) apply_word(on_bus);
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold the word until it is taken
      end else if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pending_q.size() != 0) begin
        on_bus = pending_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_DATA_W'({on_bus.b, on_bus.g, on_bus.r, on_bus.idx, on_bus.dt});
        s_axis_tuser <= on_bus.mode;
        send_gap <= (throttle_in && $urandom_range(0, 99) < 35) ? pick_gap() : 0;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Output monitor: check result words, stall the output at random
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      hold_left <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_word(m_axis_tdata);
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        m_axis_tready <= 1'b0;
      end else if (throttle_out && $urandom_range(0, 99) < 30) begin
        hold_left <= pick_gap() - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: stop when no handshake happens for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", IDLE_LIMIT);
      $display("tb_palette_fade_sequencer_core: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int unsigned chunk;
    int unsigned n;
    int unsigned random_made;
    int unsigned done_chunks;
    logic [TPS_W-1:0] tps_pick;
    logic [SIZE_W-1:0] size_pick;
    chunk = 0;
    random_made = 0;
    done_chunks = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: fill every entry, the first five with extremes, then reads and reveal ticks
    enqueue_word(MODE_WRITE, '0, 4'd0, 8'hFF, 8'hFF, 8'hFF);
    enqueue_word(MODE_WRITE, '1, 4'd1, 8'h00, 8'h00, 8'h00);
    enqueue_word(MODE_WRITE, '0, 4'd2, 8'hFF, 8'h00, 8'h00);
    enqueue_word(MODE_WRITE, '0, 4'd3, 8'h00, 8'hFF, 8'h00);
    enqueue_word(MODE_WRITE, '0, 4'd4, 8'h00, 8'h00, 8'hFF);
    for (int i = 5; i < PALETTE_ENTRIES; i++)
      enqueue_word(MODE_WRITE, DT_W'($urandom), IDX_W'(i), pick_comp(), pick_comp(), pick_comp());
    enqueue_word(MODE_READ, '0, 4'd15, '0, '0, '0);
    enqueue_word(MODE_SPARE, '1, 4'd0, '1, '1, '1);
    enqueue_word(MODE_TICK, '0, 4'd0, '0, '0, '0);
    enqueue_word(MODE_TICK, '1, 4'd0, '0, '0, '0);
    enqueue_word(MODE_TICK, '1, 4'd2, '0, '0, '0);
    enqueue_word(MODE_TICK, '1, 4'd0, '0, '0, '0);
    enqueue_word(MODE_WRITE, DT_W'($urandom), 4'd0, 8'h80, 8'h80, 8'h80);
    enqueue_word(MODE_READ, '0, 4'd0, '0, '0, '0);
    drain_all();

    // Random phases, each under its own register setting
    while (random_made < RANDOM_ITEMS) begin
      n = $urandom_range(30, 60);
      case (chunk)
        0: begin
          tps_pick = '1;
          size_pick = SIZE_W'(16);
          n = 50;
        end
        1: begin
          tps_pick = '0;
          size_pick = '1;
          n = 12;
        end
        2: begin
          tps_pick = TPS_W'(2);
          size_pick = SIZE_W'(20);
          n = 12;
        end
        default: begin
          case (fade_ph)
            PH_REVEAL: begin
              if (reveal_cnt < 12) begin
                tps_pick = TPS_W'($urandom_range(150000, 600000));
                size_pick = $urandom_range(0, 1) ? SIZE_W'(16) : '1;
              end else begin
                // shrink the palette so the reveal ends, sometimes to nothing
                tps_pick = TPS_W'($urandom_range(100000, 1000000));
                size_pick = SIZE_W'($urandom_range(0, reveal_cnt));
              end
            end
            PH_WHITE, PH_BACK: begin
              tps_pick = ($urandom_range(0, 9) == 0) ? TPS_W'(1) :
                         TPS_W'($urandom_range(100000, 1000000));
              size_pick = SIZE_W'($urandom_range(1, 31));
            end
            default: begin
              if (done_chunks == 0) begin
                tps_pick = TPS_W'(2);
                size_pick = SIZE_W'(1);
              end else begin
                tps_pick = $urandom_range(0, 1) ? '1 : TPS_W'($urandom_range(2, 16777215));
                size_pick = SIZE_W'($urandom_range(0, 31));
              end
              done_chunks++;
              n = 60;
            end
          endcase
        end
      endcase
      set_fade_config(tps_pick, size_pick);
      throttle_in <= (chunk == 0) || ($urandom_range(0, 3) != 0);
      throttle_out <= (chunk == 0) || ($urandom_range(0, 3) != 0);
      @(negedge clk);
      // Sometimes hold the sender midway until every result is back
      if (chunk == 0 || $urandom_range(0, 1)) begin
        enqueue_random(n / 2);
        drain_all();
        enqueue_random(n - n / 2);
      end else begin
        enqueue_random(n);
      end
      drain_all();
      random_made += n;
      chunk++;
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    mismatches += shown_q.size();
    $display("%0d result words checked under %0d register settings", words_checked,
             settings_used);
    $display("words per phase reveal/white/back/done: %0d/%0d/%0d/%0d", phase_hits[0],
             phase_hits[1], phase_hits[2], phase_hits[3]);
    if (mismatches == 0) begin
      $display("tb_palette_fade_sequencer_core: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_palette_fade_sequencer_core: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/pfs_pkg.sv
sv/pfs_ram.sv
sv/pfs_div.sv
sv/palette_fade_sequencer_core.sv
tb/tb_palette_fade_sequencer_core.sv
